### sv/rtcp_round_trip_time_tracker_macros.svh
// Assertion macros for the RTCP round-trip-time tracker.
`ifndef RTCP_ROUND_TRIP_TIME_TRACKER_MACROS_SVH
`define RTCP_ROUND_TRIP_TIME_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RTT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RTT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rtcp_pkg.sv
// Shared types and constants of the RTCP round-trip-time tracker.
`timescale 1ns / 1ps
`default_nettype none

package rtcp_pkg;

    localparam int SR_LIMIT     = 5;
    localparam int PEER_ENTRIES = 8;

    localparam int SR_IDX_W   = (SR_LIMIT > 1) ? $clog2(SR_LIMIT) : 1;
    localparam int SR_CNT_W   = $clog2(SR_LIMIT + 1);
    localparam int PEER_IDX_W = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1;

    // dlsr * 1000 / 65536 stays below 2^26
    localparam int DLSR_SCALE = 1000;
    localparam int DLSR_SHIFT = 16;
    localparam int PROD_W     = 32 + $clog2(DLSR_SCALE);
    localparam int DELAY_W    = PROD_W - DLSR_SHIFT;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_RTP   = 2'd0,
        MODE_SR    = 2'd1,
        MODE_RR    = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t               op;
        logic [31:0]         ssrc;
        logic [31:0]         lsr_key;
        logic                lsr_zero;
        logic [DELAY_W-1:0]  delay;
        logic [31:0]         now_lo;
        logic [15:0]         byte_count;
        logic [31:0]         rtp_stamp;
    } cmd_t;

    typedef struct packed {
        logic                idle;
        logic                rtp_exec;
        logic                evict;
        logic [SR_CNT_W-1:0] sr_count;
        logic [31:0]         pkt_count;
    } back_status_t;

endpackage

`default_nettype wire

### sv/rtcp_front.sv
// Front end: accepts items, decodes the mode and scales the DLSR delay.
`timescale 1ns / 1ps
`default_nettype none

module rtcp_front (
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           mode,
    input  wire logic [31:0]          ssrc,
    input  wire logic [31:0]          lsr_key,
    input  wire logic [31:0]          dlsr,
    input  wire logic [63:0]          now_ms,
    input  wire logic [15:0]          byte_count,
    input  wire logic [31:0]          rtp_stamp,
    input  wire logic                 q_full,
    output logic                      q_wr_en,
    output rtcp_pkg::cmd_t            q_wr_data
);
    import rtcp_pkg::*;

    logic [PROD_W-1:0] prod;

    // one narrow multiply; the queue entry registers it
    assign prod = PROD_W'(dlsr) * PROD_W'(DLSR_SCALE);

    assign in_ready = !q_full;
    assign q_wr_en  = in_valid && !q_full;

    always_comb
    begin
        q_wr_data.op         = mode_t'(mode);
        q_wr_data.ssrc       = ssrc;
        q_wr_data.lsr_key    = lsr_key;
        q_wr_data.lsr_zero   = (lsr_key == 32'd0);
        q_wr_data.delay      = prod[PROD_W-1:DLSR_SHIFT];
        q_wr_data.now_lo     = now_ms[31:0];
        q_wr_data.byte_count = byte_count;
        q_wr_data.rtp_stamp  = rtp_stamp;
    end

endmodule

`default_nettype wire

### sv/rtcp_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module rtcp_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire rtcp_pkg::cmd_t wr_data,
    output logic                full,
    input  wire logic           rd_en,
    output rtcp_pkg::cmd_t      rd_data,
    output logic                not_empty
);
    import rtcp_pkg::*;

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_wr, do_rd;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### sv/rtcp_back.sv
// Back end: sequencer over the SR and peer tables, counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module rtcp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_not_empty,
    input  wire rtcp_pkg::cmd_t     q_rd_data,
    output logic                    q_rd_en,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [30:0]             rtt_ms,
    output logic                    rtt_updated,
    output logic [31:0]             packet_total,
    output logic [31:0]             octet_total,
    output logic [31:0]             last_stamp,
    output rtcp_pkg::back_status_t  status
);
    import rtcp_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EXEC  = 6'b000010,
        ST_PEER  = 6'b000100,
        ST_EVICT = 6'b001000,
        ST_DONE  = 6'b010000,
        ST_SPARE = 6'b100000
    } back_state_t;

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;

    // tables: keys and times have no reset, the used bits guard them
    logic [31:0]            sr_key_reg   [SR_LIMIT];
    logic [31:0]            sr_time_reg  [SR_LIMIT];
    logic [SR_LIMIT-1:0]    sr_used_reg, sr_used_next;
    logic [31:0]            peer_ssrc_reg [PEER_ENTRIES];
    logic [30:0]            peer_rtt_reg  [PEER_ENTRIES];
    logic [PEER_ENTRIES-1:0] peer_used_reg, peer_used_next;

    logic [31:0] pkt_reg, pkt_next;
    logic [31:0] oct_reg, oct_next;
    logic [31:0] stamp_reg, stamp_next;

    logic [31:0]         diff_reg, diff_next;
    logic [30:0]         res_rtt_reg, res_rtt_next;
    logic                res_upd_reg, res_upd_next;
    logic [SR_IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [SR_IDX_W-1:0] low_idx_reg, low_idx_next;
    logic [31:0]         low_key_reg, low_key_next;
    logic                low_found_reg, low_found_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_load;

    logic [30:0] out_rtt_reg;
    logic        out_upd_reg;
    logic [31:0] out_pkt_reg, out_oct_reg, out_stamp_reg;

    logic                  sr_hit, sr_free;
    logic [SR_IDX_W-1:0]   sr_hit_idx, sr_free_idx;
    logic                  peer_hit, peer_free;
    logic [PEER_IDX_W-1:0] peer_hit_idx, peer_free_idx;
    logic [SR_CNT_W-1:0]   sr_count;
    logic                  take_low, scan_last;
    logic [SR_IDX_W-1:0]   cand_idx;

    logic                  sr_key_we, sr_time_we;
    logic [SR_IDX_W-1:0]   sr_wr_idx;
    logic                  peer_ssrc_we, peer_rtt_we;
    logic [PEER_IDX_W-1:0] peer_wr_idx;

    // associative match and first-free search across entries
    always_comb
    begin
        sr_hit      = 1'b0;
        sr_hit_idx  = '0;
        sr_free     = 1'b0;
        sr_free_idx = '0;
        for (int i = 0; i < SR_LIMIT; i++)
        begin
            if (!sr_hit && sr_used_reg[i] && sr_key_reg[i] == cmd_reg.lsr_key)
            begin
                sr_hit     = 1'b1;
                sr_hit_idx = SR_IDX_W'(i);
            end
            if (!sr_free && !sr_used_reg[i])
            begin
                sr_free     = 1'b1;
                sr_free_idx = SR_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        peer_hit      = 1'b0;
        peer_hit_idx  = '0;
        peer_free     = 1'b0;
        peer_free_idx = '0;
        for (int i = 0; i < PEER_ENTRIES; i++)
        begin
            if (!peer_hit && peer_used_reg[i] && peer_ssrc_reg[i] == cmd_reg.ssrc)
            begin
                peer_hit     = 1'b1;
                peer_hit_idx = PEER_IDX_W'(i);
            end
            if (!peer_free && !peer_used_reg[i])
            begin
                peer_free     = 1'b1;
                peer_free_idx = PEER_IDX_W'(i);
            end
        end
    end

    assign sr_count  = SR_CNT_W'($countones(sr_used_reg));
    assign scan_last = (scan_idx_reg == SR_IDX_W'(SR_LIMIT - 1));
    assign take_low  = sr_used_reg[scan_idx_reg]
                       && (!low_found_reg || sr_key_reg[scan_idx_reg] < low_key_reg);
    assign cand_idx  = take_low ? scan_idx_reg : low_idx_reg;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        sr_used_next   = sr_used_reg;
        peer_used_next = peer_used_reg;
        pkt_next       = pkt_reg;
        oct_next       = oct_reg;
        stamp_next     = stamp_reg;
        diff_next      = diff_reg;
        res_rtt_next   = res_rtt_reg;
        res_upd_next   = res_upd_reg;
        scan_idx_next  = scan_idx_reg;
        low_idx_next   = low_idx_reg;
        low_key_next   = low_key_reg;
        low_found_next = low_found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_rd_en        = 1'b0;
        sr_key_we      = 1'b0;
        sr_time_we     = 1'b0;
        sr_wr_idx      = sr_hit_idx;
        peer_ssrc_we   = 1'b0;
        peer_rtt_we    = 1'b0;
        peer_wr_idx    = peer_hit_idx;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_rd_en    = 1'b1;
                    cmd_next   = q_rd_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_rtt_next = '0;
                res_upd_next = 1'b0;
                state_next   = ST_DONE;
                case (cmd_reg.op)
                    MODE_RTP:
                    begin
                        pkt_next   = pkt_reg + 32'd1;
                        oct_next   = oct_reg + {16'd0, cmd_reg.byte_count};
                        stamp_next = cmd_reg.rtp_stamp;
                    end
                    MODE_SR:
                    begin
                        if (sr_hit)
                        begin
                            // repeated key: refresh its time only
                            sr_time_we = 1'b1;
                        end
                        else if (sr_free)
                        begin
                            sr_key_we               = 1'b1;
                            sr_time_we              = 1'b1;
                            sr_wr_idx               = sr_free_idx;
                            sr_used_next[sr_free_idx] = 1'b1;
                            scan_idx_next           = '0;
                            low_found_next          = 1'b0;
                            state_next              = ST_EVICT;
                        end
                    end
                    MODE_RR:
                    begin
                        if (!cmd_reg.lsr_zero && sr_hit)
                        begin
                            diff_next = cmd_reg.now_lo - sr_time_reg[sr_hit_idx]
                                        - {{(32 - DELAY_W){1'b0}}, cmd_reg.delay};
                            state_next = ST_PEER;
                        end
                    end
                    default:
                    begin
                        if (peer_hit)
                        begin
                            res_rtt_next = peer_rtt_reg[peer_hit_idx];
                        end
                    end
                endcase
            end
            ST_PEER:
            begin
                // negative RTT or full table: drop
                if (!diff_reg[31])
                begin
                    if (peer_hit)
                    begin
                        peer_rtt_we  = 1'b1;
                        res_upd_next = 1'b1;
                        res_rtt_next = diff_reg[30:0];
                    end
                    else if (peer_free)
                    begin
                        peer_wr_idx                  = peer_free_idx;
                        peer_ssrc_we                 = 1'b1;
                        peer_rtt_we                  = 1'b1;
                        peer_used_next[peer_free_idx] = 1'b1;
                        res_upd_next                 = 1'b1;
                        res_rtt_next                 = diff_reg[30:0];
                    end
                end
                state_next = ST_DONE;
            end
            ST_EVICT:
            begin
                // walk the SR table one entry a cycle for the smallest key
                if (take_low)
                begin
                    low_idx_next   = scan_idx_reg;
                    low_key_next   = sr_key_reg[scan_idx_reg];
                    low_found_next = 1'b1;
                end
                if (scan_last)
                begin
                    if (sr_count >= SR_CNT_W'(SR_LIMIT))
                    begin
                        sr_used_next[cand_idx] = 1'b0;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sr_used_reg   <= '0;
            peer_used_reg <= '0;
            pkt_reg       <= '0;
            oct_reg       <= '0;
            stamp_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sr_used_reg   <= sr_used_next;
            peer_used_reg <= peer_used_next;
            pkt_reg       <= pkt_next;
            oct_reg       <= oct_next;
            stamp_reg     <= stamp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        diff_reg      <= diff_next;
        res_rtt_reg   <= res_rtt_next;
        res_upd_reg   <= res_upd_next;
        scan_idx_reg  <= scan_idx_next;
        low_idx_reg   <= low_idx_next;
        low_key_reg   <= low_key_next;
        low_found_reg <= low_found_next;
        if (sr_key_we)
        begin
            sr_key_reg[sr_wr_idx] <= cmd_reg.lsr_key;
        end
        if (sr_time_we)
        begin
            sr_time_reg[sr_wr_idx] <= cmd_reg.now_lo;
        end
        if (peer_ssrc_we)
        begin
            peer_ssrc_reg[peer_wr_idx] <= cmd_reg.ssrc;
        end
        if (peer_rtt_we)
        begin
            peer_rtt_reg[peer_wr_idx] <= diff_reg[30:0];
        end
        if (out_load)
        begin
            out_rtt_reg   <= res_rtt_reg;
            out_upd_reg   <= res_upd_reg;
            out_pkt_reg   <= pkt_reg;
            out_oct_reg   <= oct_reg;
            out_stamp_reg <= stamp_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rtt_ms       = out_rtt_reg;
    assign rtt_updated  = out_upd_reg;
    assign packet_total = out_pkt_reg;
    assign octet_total  = out_oct_reg;
    assign last_stamp   = out_stamp_reg;

    always_comb
    begin
        status.idle      = (state_reg == ST_IDLE);
        status.rtp_exec  = (state_reg == ST_EXEC) && (cmd_reg.op == MODE_RTP);
        status.evict     = (state_reg == ST_EVICT);
        status.sr_count  = sr_count;
        status.pkt_count = pkt_reg;
    end

endmodule

`default_nettype wire

### sv/rtcp_round_trip_time_tracker.sv
// Path: the front end writes the queue; the back end takes an item in idle and runs it in exec.
// Count, query, repeated SR key and an unmatched report block then go to done; a matched
// report block passes the peer step, a new SR key the min-key walk; done waits for a free output.
// The back-end sequencer takes one item at a time; its min-key walk visits one entry a cycle.
// A 2-entry queue keeps accepting until full while the back end works or a result waits.
// Reset (rst_n low, async) clears counters, valid bits of both tables and the queue.
`timescale 1ns / 1ps
`default_nettype none

`include "rtcp_round_trip_time_tracker_macros.svh"

module rtcp_round_trip_time_tracker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] ssrc,
    input  wire logic [31:0] lsr_key,
    input  wire logic [31:0] dlsr,
    input  wire logic [63:0] now_ms,
    input  wire logic [15:0] byte_count,
    input  wire logic [31:0] rtp_stamp,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [30:0]      rtt_ms,
    output logic             rtt_updated,
    output logic [31:0]      packet_total,
    output logic [31:0]      octet_total,
    output logic [31:0]      last_stamp
);
    import rtcp_pkg::*;

    logic         q_full, q_wr_en, q_rd_en, q_not_empty;
    cmd_t         q_wr_data, q_rd_data;
    back_status_t st;

    rtcp_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .ssrc       (ssrc),
        .lsr_key    (lsr_key),
        .dlsr       (dlsr),
        .now_ms     (now_ms),
        .byte_count (byte_count),
        .rtp_stamp  (rtp_stamp),
        .q_full     (q_full),
        .q_wr_en    (q_wr_en),
        .q_wr_data  (q_wr_data)
    );

    rtcp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_wr_en),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .rd_en     (q_rd_en),
        .rd_data   (q_rd_data),
        .not_empty (q_not_empty)
    );

    rtcp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_rd_data    (q_rd_data),
        .q_rd_en      (q_rd_en),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rtt_ms       (rtt_ms),
        .rtt_updated  (rtt_updated),
        .packet_total (packet_total),
        .octet_total  (octet_total),
        .last_stamp   (last_stamp),
        .status       (st)
    );

    // eviction leaves the SR table below its limit between items
    `RTT_ASSERT_IMP(a_sr_below_limit, st.idle, st.sr_count < SR_CNT_W'(SR_LIMIT), "SR table at limit while idle")
    // only a counted RTP packet moves the packet counter
    `RTT_ASSERT_NXT(a_pkt_hold, !st.rtp_exec, $stable(st.pkt_count), "packet counter moved without RTP item")
    // the min-key walk only runs after an insertion
    `RTT_ASSERT_IMP(a_evict_nonempty, st.evict, st.sr_count != '0, "eviction walk on empty SR table")

endmodule

`default_nettype wire
